FILE: rtl/bic_pkg.sv
// Shared constants and types for the banked interrupt controller.
// No dependencies; every other file imports this package.
package bic_pkg;

    localparam int BASIC_SOURCES = 8;
    localparam int BANK_SOURCES  = 32;
    localparam int BANK_ONE_BASE = BASIC_SOURCES;
    localparam int BANK_TWO_BASE = BASIC_SOURCES + BANK_SOURCES;
    localparam int TOTAL_SOURCES = BASIC_SOURCES + 2 * BANK_SOURCES;

    // Field widths of the request and response payloads
    localparam int KIND_W  = 2;
    localparam int NUM_W   = 7;
    localparam int LAST_W  = 8;
    localparam int BASIC_W = 8;
    localparam int BANK_W  = 32;

    typedef enum logic [KIND_W-1:0] {
        KIND_MASK   = 2'd0,
        KIND_UNMASK = 2'd1,
        KIND_QUERY  = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    // Enable bit update issued by the control stage
    typedef struct packed {
        logic             write;
        logic             set;
        logic [NUM_W-1:0] index;
    } t_enable_cmd;

    // Outcome of the next-pending search
    typedef struct packed {
        logic             found;
        logic [NUM_W-1:0] next_irq;
    } t_pick;

endpackage

FILE: rtl/bic_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on bic_pkg for the field widths.
interface bic_req_if import bic_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic [NUM_W-1:0]         irq_number;
    logic signed [LAST_W-1:0] prev_irq;
    logic [BASIC_W-1:0]       lines_basic;
    logic [BANK_W-1:0]        lines_bank_one;
    logic [BANK_W-1:0]        lines_bank_two;

    modport source (output valid, kind, irq_number, prev_irq, lines_basic,
                    lines_bank_one, lines_bank_two, input ready);
    modport sink   (input valid, kind, irq_number, prev_irq, lines_basic,
                    lines_bank_one, lines_bank_two, output ready);
endinterface

interface bic_rsp_if import bic_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             found;
    logic [NUM_W-1:0] next_irq;
    logic             bad_number;

    modport source (output valid, found, next_irq, bad_number, input ready);
    modport sink   (input valid, found, next_irq, bad_number, output ready);
endinterface

FILE: rtl/banked_interrupt_controller.sv
// Top level of the banked interrupt controller: request register, enable
// bits, next-pending search and response register. Depends on bic_pkg,
// bic_if, bic_enable_regs and bic_next_pending.
//
//   port    | dir | transfer carries
//   --------+-----+---------------------------------------------------------
//   i_req   | in  | kind, irq_number, prev_irq, lines_basic/bank_one/bank_two
//   o_rsp   | out | found, next_irq, bad_number
//
// Each request passes through the request register, then through the enable
// update and priority search into the response register. A new request is
// taken every cycle while the response is not stalled.
// Reset clears all enable bits and empties both registers.
// A stalled response holds the request register; the input keeps accepting
// while the request register is empty or moves on in the same cycle.
module banked_interrupt_controller import bic_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    bic_req_if.sink   i_req,
    bic_rsp_if.source o_rsp
);

    logic                     r_in_valid;
    t_kind                    r_kind;
    logic [NUM_W-1:0]         r_irq_number;
    logic signed [LAST_W-1:0] r_prev_irq;
    logic [TOTAL_SOURCES-1:0] r_lines;

    logic             r_out_valid;
    logic             r_found;
    logic [NUM_W-1:0] r_next_irq;
    logic             r_bad;

    logic                     advance;
    logic                     num_ok;
    t_enable_cmd              cmd;
    logic [TOTAL_SOURCES-1:0] enable;
    t_pick                    pick;
    logic                     n_found;
    logic [NUM_W-1:0]         n_next_irq;
    logic                     n_bad;

    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || advance;
    assign num_ok      = (r_irq_number < NUM_W'(TOTAL_SOURCES));

    always_comb begin
        cmd        = '0;
        n_found    = 1'b0;
        n_next_irq = '0;
        n_bad      = 1'b0;
        case (r_kind)
            KIND_MASK, KIND_UNMASK: begin
                cmd.write = advance && num_ok;
                cmd.set   = (r_kind == KIND_UNMASK);
                cmd.index = r_irq_number;
                n_bad     = !num_ok;
            end
            KIND_QUERY: begin
                n_found    = pick.found;
                n_next_irq = pick.found ? pick.next_irq : '0;
            end
            default: begin
            end
        endcase
    end

    bic_enable_regs u_enable (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_enable (enable)
    );

    bic_next_pending u_pick (
        .i_lines    (r_lines),
        .i_enable   (enable),
        .i_prev_irq (r_prev_irq),
        .o_pick     (pick)
    );

    // request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_kind       <= t_kind'(i_req.kind);
            r_irq_number <= i_req.irq_number;
            r_prev_irq   <= i_req.prev_irq;
            r_lines      <= {i_req.lines_bank_two, i_req.lines_bank_one,
                             i_req.lines_basic};
        end
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_found    <= n_found;
            r_next_irq <= n_next_irq;
            r_bad      <= n_bad;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.found      = r_found;
    assign o_rsp.next_irq   = r_next_irq;
    assign o_rsp.bad_number = r_bad;

endmodule

FILE: rtl/bic_enable_regs.sv
// Per-source enable bits with set/clear by source number.
// Depends on bic_pkg.
module bic_enable_regs import bic_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_enable_cmd              i_cmd,
    output logic [TOTAL_SOURCES-1:0] o_enable
);

    logic [TOTAL_SOURCES-1:0] r_enable;
    logic [TOTAL_SOURCES-1:0] n_enable;

    always_comb begin
        n_enable = r_enable;
        if (i_cmd.write) begin
            n_enable[i_cmd.index] = i_cmd.set;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= '0;
        end else begin
            r_enable <= n_enable;
        end
    end

    assign o_enable = r_enable;

endmodule

FILE: rtl/bic_next_pending.sv
// Lowest enabled pending source strictly above the last handled number.
// Depends on bic_pkg; purely combinational.
module bic_next_pending import bic_pkg::*; (
    input  logic [TOTAL_SOURCES-1:0] i_lines,
    input  logic [TOTAL_SOURCES-1:0] i_enable,
    input  logic signed [LAST_W-1:0] i_prev_irq,
    output t_pick                    o_pick
);

    logic signed [LAST_W:0]   start_s;
    logic [LAST_W-1:0]        start;
    logic [TOTAL_SOURCES-1:0] window;
    logic [TOTAL_SOURCES-1:0] cand;
    logic [TOTAL_SOURCES-1:0] lowest;
    logic [NUM_W-1:0]         code;

    always_comb begin
        // a negative start clamps to source zero
        start_s = {i_prev_irq[LAST_W-1], i_prev_irq} + (LAST_W+1)'(1);
        start   = start_s[LAST_W] ? '0 : start_s[LAST_W-1:0];
        for (int i = 0; i < TOTAL_SOURCES; i++) begin
            window[i] = (LAST_W'(i) >= start);
        end
        cand   = i_lines & i_enable & window;
        // isolate the lowest set bit, then encode it
        lowest = cand & (~cand + TOTAL_SOURCES'(1));
        code   = '0;
        for (int i = 0; i < TOTAL_SOURCES; i++) begin
            code = code | ({NUM_W{lowest[i]}} & NUM_W'(i));
        end
        o_pick.found    = |cand;
        o_pick.next_irq = code;
    end

endmodule
